// ===== rtl/core/tl_pkg.sv =====
// Shared types, constants and byte helpers for the token lexer.
// No dependencies; the lexer modules and the token checker import this package.
`default_nettype none
package tl_pkg;

  // Width of the running byte position (saturating counter).
  localparam int unsigned PosBits = 16;
  // Depth of the token queue between the front and back parts.
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QAw     = $clog2(QDepth);
  localparam int unsigned QCw     = $clog2(QDepth + 1);

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);

  typedef enum logic [4:0] {
    KSemi    = 5'd0,
    KColon   = 5'd1,
    KStar    = 5'd2,
    KLParen  = 5'd3,
    KRParen  = 5'd4,
    KLBrack  = 5'd5,
    KRBrack  = 5'd6,
    KLBrace  = 5'd7,
    KRBrace  = 5'd8,
    KEqual   = 5'd9,
    KEnd     = 5'd10,
    KUnder   = 5'd11,
    KString  = 5'd12,
    KIdent   = 5'd13,
    KBool    = 5'd14,
    KInt     = 5'd15,
    KFloat   = 5'd16,
    KUnknown = 5'd17,
    KUnterm  = 5'd18
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
  } tok_t;

  // One queue word: the tokens caused by a single text byte.
  typedef struct packed {
    tok_t t0;
    tok_t t1;
    logic two;
  } qent_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h61:8'h7A]}) || (b inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
  endfunction

  function automatic logic [PosBits-1:0] pos_inc(input logic [PosBits-1:0] p);
    return (p == PosMax) ? PosMax : p + PosOne;
  endfunction

  function automatic logic [PosBits-1:0] span(input logic [PosBits-1:0] s,
                                               input logic [PosBits-1:0] p);
    return (s > p) ? '0 : p - s;
  endfunction

  // Build a token: offset keeps the low 16 bits, length saturates.
  function automatic tok_t make_tok(input tok_kind_e k,
                                    input logic [PosBits-1:0] s,
                                    input logic [PosBits-1:0] l);
    tok_t        t;
    logic [31:0] sw;
    logic [31:0] lw;
    sw      = 32'(s);
    lw      = 32'(l);
    t.kind  = k;
    t.start = sw[15:0];
    t.len   = (lw > 32'h0000_FFFF) ? 16'hFFFF : lw[15:0];
    return t;
  endfunction

  // Keyword tracker: 1..4 follow "true", 5..9 follow "false".
  function automatic logic [3:0] kw_next(input logic [3:0] m, input logic [7:0] b);
    logic [3:0] r;
    r = 4'd0;
    case (m)
      4'd1: if (b == 8'h72) r = 4'd2;
      4'd2: if (b == 8'h75) r = 4'd3;
      4'd3: if (b == 8'h65) r = 4'd4;
      4'd5: if (b == 8'h61) r = 4'd6;
      4'd6: if (b == 8'h6C) r = 4'd7;
      4'd7: if (b == 8'h73) r = 4'd8;
      4'd8: if (b == 8'h65) r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tl_byte_if.sv =====
// Text byte channel: valid/ready handshake carrying one byte per word.
// No dependencies.
`default_nettype none
interface tl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tl_tok_if.sv =====
// Token channel: valid/ready handshake carrying one token per word.
// No dependencies.
`default_nettype none
interface tl_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] text_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset,
                  output text_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input text_length, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/token_lexer.sv =====
// Streaming tokenizer top level: one text byte per word in, one token per word out.
// A byte's first token is written into the queue, then into the output register.
// Throughput: one byte per cycle, and one token per cycle while the output is ready;
// a byte that closes one token and emits another yields two token words, and the
// four-word queue absorbs such bursts; the input stalls only while the queue is full.
// Asynchronous active-low reset clears the scan state, the position, the queue
// pointers and count, and the output valid and pending flags.
// Depends on tl_pkg, tl_byte_if, tl_tok_if, tl_front, tl_queue, tl_back.
`default_nettype none
module token_lexer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tl_byte_if.sink   text_i,
  tl_tok_if.source  token_o
);
  import tl_pkg::*;

  // front to queue: tokens of each accepted byte
  logic  push;
  qent_t push_data;
  logic  full;

  // queue to back: oldest byte's tokens
  logic  pop;
  qent_t pop_data;
  logic  empty;

  // Classify each byte and advance the scan state; stall only on a full queue.
  tl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Decouple the two sides so an output stall does not stop the scan at once.
  tl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  // Serialise token pairs and mark the last token of each byte.
  tl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .token_o    (token_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tl_front.sv =====
// Lexer front part: accepts text bytes, runs the scan state and pushes
// the tokens of each byte into the queue. Depends on tl_pkg, tl_byte_if.
`default_nettype none
module tl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tl_byte_if.sink            text_i,
  output      logic          push_o,
  output      tl_pkg::qent_t push_data_o,
  input  wire logic          full_i
);
  import tl_pkg::*;

  localparam logic [2:0] ModeIdle    = 3'd0;
  localparam logic [2:0] ModeLine    = 3'd1;
  localparam logic [2:0] ModeBlock   = 3'd2;
  localparam logic [2:0] ModeString  = 3'd3;
  localparam logic [2:0] ModeIdent   = 3'd4;
  localparam logic [2:0] ModeNum     = 3'd5;
  localparam logic [2:0] ModeNumMark = 3'd6;

  logic [2:0]         mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] tstart_q, tstart_d;
  logic               frac_q, frac_d;
  logic               esc_q, esc_d;
  logic               slash_q, slash_d;
  logic               star_q, star_d;
  logic [3:0]         kw_q, kw_d;

  logic       accept;
  logic [7:0] b;
  logic       fresh;
  logic       pre_v, idle_v;
  tok_t       pre_tok, idle_tok;

  assign text_i.ready = ~full_i;
  assign accept       = text_i.valid & ~full_i;
  assign b            = text_i.text_byte;

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    tstart_d = tstart_q;
    frac_d   = frac_q;
    esc_d    = esc_q;
    slash_d  = slash_q;
    star_d   = star_q;
    kw_d     = kw_q;
    fresh    = 1'b0;
    pre_v    = 1'b0;
    idle_v   = 1'b0;
    pre_tok  = '0;
    idle_tok = '0;

    if (b == 8'h00) begin
      // end of stream: close what is pending, then emit end
      case (mode_q)
        ModeIdent: begin
          pre_v   = 1'b1;
          pre_tok = make_tok((kw_q == 4'd4 || kw_q == 4'd9) ? KBool : KIdent,
                             tstart_q, span(tstart_q, pos_q));
        end
        ModeNum, ModeNumMark: begin
          pre_v   = 1'b1;
          pre_tok = make_tok(frac_q ? KFloat : KInt, tstart_q, span(tstart_q, pos_q));
        end
        ModeString, ModeLine, ModeBlock: begin
          pre_v   = 1'b1;
          pre_tok = make_tok(KUnterm, tstart_q, span(tstart_q, pos_q));
        end
        default: begin
          if (slash_q) begin
            pre_v   = 1'b1;
            pre_tok = make_tok(KUnknown, tstart_q, PosOne);
          end
        end
      endcase
      idle_v   = 1'b1;
      idle_tok = make_tok(KEnd, pos_q, PosOne);
      mode_d   = ModeIdle;
      pos_d    = '0;
      tstart_d = '0;
      frac_d   = 1'b0;
      esc_d    = 1'b0;
      slash_d  = 1'b0;
      star_d   = 1'b0;
      kw_d     = 4'd0;
    end else begin
      case (mode_q)
        ModeLine: begin
          if (b == 8'h0A || b == 8'h0D) mode_d = ModeIdle;
        end
        ModeBlock: begin
          if (star_q && b == 8'h2F) begin
            mode_d = ModeIdle;
            star_d = 1'b0;
          end else begin
            star_d = (b == 8'h2A);
          end
        end
        ModeString: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (b == 8'h5C) begin
            esc_d = 1'b1;
          end else if (b == 8'h22) begin
            pre_v   = 1'b1;
            pre_tok = make_tok(KString, tstart_q, span(tstart_q, pos_q));
            mode_d  = ModeIdle;
          end
        end
        ModeIdent: begin
          if (is_alpha(b) || is_digit(b) || b == 8'h5F || b == 8'h3A) begin
            kw_d = kw_next(kw_q, b);
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok((kw_q == 4'd4 || kw_q == 4'd9) ? KBool : KIdent,
                               tstart_q, span(tstart_q, pos_q));
            fresh   = 1'b1;
          end
        end
        ModeNum: begin
          if (is_digit(b)) begin
            mode_d = ModeNum;
          end else if (b == 8'h2E || b == 8'h66) begin
            frac_d = 1'b1;
            mode_d = ModeNumMark;
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok(frac_q ? KFloat : KInt, tstart_q, span(tstart_q, pos_q));
            fresh   = 1'b1;
          end
        end
        ModeNumMark: begin
          if (is_digit(b)) begin
            mode_d = ModeNum;
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok(frac_q ? KFloat : KInt, tstart_q, span(tstart_q, pos_q));
            fresh   = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        // a pending slash either opens a comment or becomes unknown
        if (slash_q && b == 8'h2F) begin
          slash_d = 1'b0;
          mode_d  = ModeLine;
        end else if (slash_q && b == 8'h2A) begin
          slash_d = 1'b0;
          mode_d  = ModeBlock;
          star_d  = 1'b0;
        end else begin
          if (slash_q) begin
            slash_d = 1'b0;
            pre_v   = 1'b1;
            pre_tok = make_tok(KUnknown, tstart_q, PosOne);
          end
          mode_d = ModeIdle;
          case (b)
            8'h3B: begin idle_v = 1'b1; idle_tok = make_tok(KSemi,   pos_q, PosOne); end
            8'h3A: begin idle_v = 1'b1; idle_tok = make_tok(KColon,  pos_q, PosOne); end
            8'h2A: begin idle_v = 1'b1; idle_tok = make_tok(KStar,   pos_q, PosOne); end
            8'h28: begin idle_v = 1'b1; idle_tok = make_tok(KLParen, pos_q, PosOne); end
            8'h29: begin idle_v = 1'b1; idle_tok = make_tok(KRParen, pos_q, PosOne); end
            8'h5B: begin idle_v = 1'b1; idle_tok = make_tok(KLBrack, pos_q, PosOne); end
            8'h5D: begin idle_v = 1'b1; idle_tok = make_tok(KRBrack, pos_q, PosOne); end
            8'h7B: begin idle_v = 1'b1; idle_tok = make_tok(KLBrace, pos_q, PosOne); end
            8'h7D: begin idle_v = 1'b1; idle_tok = make_tok(KRBrace, pos_q, PosOne); end
            8'h3D: begin idle_v = 1'b1; idle_tok = make_tok(KEqual,  pos_q, PosOne); end
            8'h5F: begin idle_v = 1'b1; idle_tok = make_tok(KUnder,  pos_q, PosOne); end
            8'h2F: begin
              slash_d  = 1'b1;
              tstart_d = pos_q;
            end
            8'h22: begin
              mode_d   = ModeString;
              esc_d    = 1'b0;
              tstart_d = pos_inc(pos_q);
            end
            default: begin
              if (is_space(b)) begin
                mode_d = ModeIdle;
              end else if (is_alpha(b)) begin
                mode_d   = ModeIdent;
                tstart_d = pos_q;
                kw_d     = (b == 8'h74) ? 4'd1 : ((b == 8'h66) ? 4'd5 : 4'd0);
              end else if (is_digit(b)) begin
                mode_d   = ModeNum;
                tstart_d = pos_q;
                frac_d   = 1'b0;
              end else begin
                idle_v   = 1'b1;
                idle_tok = make_tok(KUnknown, pos_q, PosOne);
              end
            end
          endcase
        end
      end
      pos_d = pos_inc(pos_q);
    end
  end

  // pack the byte's tokens, first in order into slot zero
  always_comb begin
    push_data_o.t0  = pre_v ? pre_tok : idle_tok;
    push_data_o.t1  = idle_tok;
    push_data_o.two = pre_v & idle_v;
  end
  assign push_o = accept & (pre_v | idle_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pos_q    <= '0;
      tstart_q <= '0;
      frac_q   <= 1'b0;
      esc_q    <= 1'b0;
      slash_q  <= 1'b0;
      star_q   <= 1'b0;
      kw_q     <= 4'd0;
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
      frac_q   <= frac_d;
      esc_q    <= esc_d;
      slash_q  <= slash_d;
      star_q   <= star_d;
      kw_q     <= kw_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tl_queue.sv =====
// Short token queue between the lexer front and the output back part.
// Depends on tl_pkg.
`default_nettype none
module tl_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tl_pkg::qent_t push_data_i,
  input  wire logic          pop_i,
  output      tl_pkg::qent_t pop_data_o,
  output      logic          full_o,
  output      logic          empty_o
);
  import tl_pkg::*;

  qent_t          mem_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QCw-1:0] cnt_q;
  logic           do_push, do_pop;

  assign full_o     = (cnt_q == QCw'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= QAw'((32'(wr_q) + 1) % QDepth);
      if (do_pop)  rd_q <= QAw'((32'(rd_q) + 1) % QDepth);
      if (do_push && !do_pop) cnt_q <= cnt_q + QCw'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCw'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tl_back.sv =====
// Lexer back part: pops token pairs from the queue and drives them out
// one word at a time through an output register. Depends on tl_pkg, tl_tok_if.
`default_nettype none
module tl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tl_pkg::qent_t pop_data_i,
  input  wire logic          empty_i,
  output      logic          pop_o,
  tl_tok_if.source           token_o
);
  import tl_pkg::*;

  logic ovalid_q, ovalid_d;
  tok_t out_q, out_d;
  logic last_q, last_d;
  logic pend_q, pend_d;
  tok_t pend_tok_q, pend_tok_d;
  logic advance;

  assign advance = ~ovalid_q | token_o.ready;

  always_comb begin
    ovalid_d   = ovalid_q;
    out_d      = out_q;
    last_d     = last_q;
    pend_d     = pend_q;
    pend_tok_d = pend_tok_q;
    pop_o      = 1'b0;
    if (advance) begin
      if (pend_q) begin
        ovalid_d = 1'b1;
        out_d    = pend_tok_q;
        last_d   = 1'b1;
        pend_d   = 1'b0;
      end else if (!empty_i) begin
        pop_o      = 1'b1;
        ovalid_d   = 1'b1;
        out_d      = pop_data_i.t0;
        last_d     = ~pop_data_i.two;
        pend_d     = pop_data_i.two;
        pend_tok_d = pop_data_i.t1;
      end else begin
        ovalid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    last_q     <= last_d;
    pend_tok_q <= pend_tok_d;
  end

  assign token_o.valid        = ovalid_q;
  assign token_o.token_kind   = out_q.kind;
  assign token_o.start_offset = out_q.start;
  assign token_o.text_length  = out_q.len;
  assign token_o.last_of_run  = last_q;

endmodule
`default_nettype wire

// ===== tb/tl_token_checker.sv =====
// Token scoreboard: predicts the token words caused by each accepted text byte
// and checks every accepted token word against the oldest prediction.
// Depends on tl_pkg (token kinds, position width), tl_byte_if and tl_tok_if.
module tl_token_checker
  import tl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tl_byte_if   text_i,
  tl_tok_if    token_i,
  output int   fail_count_o,
  output int   waiting_o
);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_LINE, SCAN_BLOCK, SCAN_STRING, SCAN_WORD, SCAN_NUMBER, SCAN_MARK
  } scan_state_e;

  typedef struct {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_word_t;

  scan_state_e        scan_state;
  logic [PosBits-1:0] byte_pos;
  logic [PosBits-1:0] tok_first;
  logic               frac_seen;
  logic               esc_seen;
  logic               slash_seen;
  logic               star_seen;
  int                 word_len;
  logic [39:0]        word_tail;   // last five bytes of the current word
  token_word_t        byte_tokens[$];
  token_word_t        expected_tokens[$];
  int                 mismatches = 0;
  int                 waiting = 0;

  assign fail_count_o = mismatches;
  assign waiting_o    = waiting;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_numeral(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Space, or tab through carriage return.
  function automatic logic is_blank(input logic [7:0] b);
    return b == " " || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [PosBits-1:0] text_span(input logic [PosBits-1:0] s,
                                                   input logic [PosBits-1:0] p);
    return (s > p) ? '0 : p - s;
  endfunction

  task automatic clear_scan();
    scan_state = SCAN_IDLE;
    byte_pos   = '0;
    tok_first  = '0;
    frac_seen  = 1'b0;
    esc_seen   = 1'b0;
    slash_seen = 1'b0;
    star_seen  = 1'b0;
    word_len   = 0;
    word_tail  = '0;
  endtask

  // A byte causes at most two tokens; drop anything beyond.
  task automatic note_token(input tok_kind_e kind, input logic [PosBits-1:0] first,
                            input logic [PosBits-1:0] len);
    token_word_t w;
    if (byte_tokens.size() >= 2) return;
    w.kind  = kind;
    w.start = 16'(first);
    w.len   = (32'(len) > 32'h0000_FFFF) ? 16'hFFFF : 16'(len);
    w.last  = 1'b0;
    byte_tokens.push_back(w);
  endtask

  task automatic close_word(input logic [PosBits-1:0] p);
    logic is_bool;
    is_bool = (word_len == 4 && word_tail[31:0] == "true") ||
              (word_len == 5 && word_tail == "false");
    note_token(is_bool ? KBool : KIdent, tok_first, text_span(tok_first, p));
  endtask

  task automatic close_number(input logic [PosBits-1:0] p);
    note_token(frac_seen ? KFloat : KInt, tok_first, text_span(tok_first, p));
  endtask

  task automatic lex_byte(input logic [7:0] b);
    logic [PosBits-1:0] p;
    logic               fresh;
    logic               taken;
    token_word_t        w;
    p     = byte_pos;
    fresh = 1'b0;
    taken = 1'b0;
    byte_tokens.delete();
    if (b == CH_NUL) begin
      case (scan_state)
        SCAN_WORD:                          close_word(p);
        SCAN_NUMBER, SCAN_MARK:             close_number(p);
        SCAN_STRING, SCAN_LINE, SCAN_BLOCK: note_token(KUnterm, tok_first,
                                                       text_span(tok_first, p));
        default: if (slash_seen) note_token(KUnknown, tok_first, 1);
      endcase
      note_token(KEnd, p, 1);
      clear_scan();
    end else begin
      case (scan_state)
        SCAN_LINE: if (b == CH_LF || b == CH_CR) scan_state = SCAN_IDLE;
        SCAN_BLOCK: begin
          if (star_seen && b == "/") begin
            scan_state = SCAN_IDLE;
            star_seen  = 1'b0;
          end else begin
            star_seen = (b == "*");
          end
        end
        SCAN_STRING: begin
          if (esc_seen) begin
            esc_seen = 1'b0;
          end else if (b == "\\") begin
            esc_seen = 1'b1;
          end else if (b == "\"") begin
            note_token(KString, tok_first, text_span(tok_first, p));
            scan_state = SCAN_IDLE;
          end
        end
        SCAN_WORD: begin
          if (is_letter(b) || is_numeral(b) || b == "_" || b == ":") begin
            word_len++;
            word_tail = {word_tail[31:0], b};
          end else begin
            close_word(p);
            fresh = 1'b1;
          end
        end
        SCAN_NUMBER: begin
          if (b == "." || b == "f") begin
            frac_seen  = 1'b1;
            scan_state = SCAN_MARK;
          end else if (!is_numeral(b)) begin
            close_number(p);
            fresh = 1'b1;
          end
        end
        SCAN_MARK: begin
          if (is_numeral(b)) begin
            scan_state = SCAN_NUMBER;
          end else begin
            close_number(p);
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      // Fresh byte: resolve a pending slash first, then start whatever comes.
      if (fresh) begin
        if (slash_seen) begin
          slash_seen = 1'b0;
          if (b == "/") begin
            scan_state = SCAN_LINE;
            taken      = 1'b1;
          end else if (b == "*") begin
            scan_state = SCAN_BLOCK;
            star_seen  = 1'b0;
            taken      = 1'b1;
          end else begin
            note_token(KUnknown, tok_first, 1);
          end
        end
        if (!taken) begin
          scan_state = SCAN_IDLE;
          case (b)
            ";": note_token(KSemi, p, 1);
            ":": note_token(KColon, p, 1);
            "*": note_token(KStar, p, 1);
            "(": note_token(KLParen, p, 1);
            ")": note_token(KRParen, p, 1);
            "[": note_token(KLBrack, p, 1);
            "]": note_token(KRBrack, p, 1);
            "{": note_token(KLBrace, p, 1);
            "}": note_token(KRBrace, p, 1);
            "=": note_token(KEqual, p, 1);
            "_": note_token(KUnder, p, 1);
            "/": begin
              slash_seen = 1'b1;
              tok_first  = p;
            end
            "\"": begin
              scan_state = SCAN_STRING;
              esc_seen   = 1'b0;
              tok_first  = (p == PosMax) ? p : p + 1'b1;
            end
            default: begin
              if (is_letter(b)) begin
                scan_state = SCAN_WORD;
                tok_first  = p;
                word_len   = 1;
                word_tail  = 40'(b);
              end else if (is_numeral(b)) begin
                scan_state = SCAN_NUMBER;
                tok_first  = p;
                frac_seen  = 1'b0;
              end else if (!is_blank(b)) begin
                note_token(KUnknown, p, 1);
              end
            end
          endcase
        end
      end
      byte_pos = (p == PosMax) ? p : p + 1'b1;
    end

    // Flag the final token of this byte.
    if (byte_tokens.size() > 0) begin
      w      = byte_tokens.pop_back();
      w.last = 1'b1;
      byte_tokens.push_back(w);
    end
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_word_t want;
    if (!rst_ni) begin
      clear_scan();
      expected_tokens.delete();
      waiting = 0;
    end else begin
      // Check before predicting: a token never leaves in the cycle its byte arrives.
      if (token_i.valid && token_i.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: token word with none expected: kind %0d start %0d len %0d last %0b",
                   $time, token_i.token_kind, token_i.start_offset, token_i.text_length,
                   token_i.last_of_run);
        end else begin
          want = expected_tokens.pop_front();
          if (token_i.token_kind !== want.kind || token_i.start_offset !== want.start ||
              token_i.text_length !== want.len || token_i.last_of_run !== want.last) begin
            mismatches++;
            $display("%0t: token mismatch: expected kind %0d start %0d len %0d last %0b",
                     $time, want.kind, want.start, want.len, want.last);
            $display("%0t:                 actual   kind %0d start %0d len %0d last %0b",
                     $time, token_i.token_kind, token_i.start_offset, token_i.text_length,
                     token_i.last_of_run);
          end
        end
      end
      if (text_i.valid && text_i.ready) lex_byte(text_i.text_byte);
      waiting = expected_tokens.size();
    end
  end

endmodule

// ===== tb/tb_token_lexer.sv =====
// Top of the token lexer testbench: clock, reset, text byte stimulus, token sink
// and the verdict. Prediction and checking live in tl_token_checker.
// Depends on tl_pkg, tl_byte_if, tl_tok_if, token_lexer and tl_token_checker.
module tb_token_lexer;

  localparam int ITEM_TARGET  = 1850;   // text bytes to send before the random part stops
  localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
  localparam int TAIL_CYCLES  = 8;      // tail wait; the pipeline is a queue plus an output register
  // Slowest correct run: under 2000 bytes, each with up to two tokens behind
  // receiver stalls, sender gaps and the hold-off, still ends far inside the
  // cycle limit below, which leaves ample margin.
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] CR_BYTE  = 8'h0D;
  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, CR_BYTE};
  localparam string      PUNCT      = ";:*()[]{}=_";

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   waiting;
  int   cycle_count    = 0;
  int   burst_left     = 0;
  int   bytes_sent     = 0;
  logic steady         = 1'b0;   // suppress sender gaps
  int   holdoff_asked  = 0;
  int   holdoff_served = 0;

  tl_byte_if text_bus ();
  tl_tok_if  token_bus ();

  token_lexer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_bus),
    .token_o(token_bus)
  );

  tl_token_checker scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_bus),
    .token_i     (token_bus),
    .fail_count_o(fail_count),
    .waiting_o   (waiting)
  );

  always #6 clk_i = ~clk_i;

  // Hard stop in case the block locks up or tokens go missing.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one byte from a falling edge and hold it until accepted. Between
  // bursts of random length, drop valid for a random gap; some bursts carry on
  // straight away so that stretches without idling occur too.
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    if (!steady && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        text_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    text_bus.valid     <= 1'b1;
    text_bus.text_byte <= b;
    do @(posedge clk_i); while (!text_bus.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_byte(s[i]);
  endtask

  // Drop valid and hold until every predicted token has been taken.
  task automatic wait_drained();
    text_bus.valid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
  endtask

  function automatic logic [7:0] random_letter();
    return ($urandom_range(0, 1) == 1) ? 8'($urandom_range("a", "z"))
                                       : 8'($urandom_range("A", "Z"));
  endfunction

  // Token sink: alternate runs of acceptance and stall of random length, and
  // serve a long hold-off whenever the stimulus asks for one.
  initial begin : token_sink
    int   run_left;
    logic accept;
    run_left        = 0;
    accept          = 1'b0;
    token_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_served != holdoff_asked) begin
        token_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holdoff_served++;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          accept   = !accept;
          run_left = accept ? (($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                           : $urandom_range(1, 8))
                            : (($urandom_range(0, 4) == 0) ? $urandom_range(4, 15)
                                                           : $urandom_range(1, 3));
        end
        run_left--;
        token_bus.ready <= accept;
      end
    end
  end

  initial begin : stimulus
    int pick;
    int len;
    int sel;
    logic [7:0] c;
    string keywords [6];
    keywords = '{"true", "false", "tru", "falsey", "t", "f"};
    text_bus.valid     = 1'b0;
    text_bus.text_byte = NUL_BYTE;
    rst_ni             = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. End of stream with nothing open, then every punctuation
    // mark and the byte extremes.
    offer_byte(NUL_BYTE);
    send_text("; : * ( ) [ ] { } = _ ");
    offer_byte(8'hFF);
    offer_byte(8'h80);
    offer_byte(8'h01);
    // Bool words, near misses and identifiers with digits, underscore and colon.
    send_text(" true false tru trueish f x_9:a\t");
    // Integers and floats: mark then digit, mark with nothing after, two marks.
    send_text("0 42;1.5 3f 7.;9..1 2.f ");
    // Strings: empty, escaped quote, escaped backslash.
    send_text("\"\" \"ab\\\"c\" \"\\\\\" ");
    // Lone slash, line comments ended by LF and CR, block comment with stars.
    send_text("/ /x // note\n//x");
    offer_byte(CR_BYTE);
    send_text("/* a * b **/;");
    // End of stream closing each kind of open token.
    send_text("abc");
    offer_byte(NUL_BYTE);
    send_text("12.");
    offer_byte(NUL_BYTE);
    send_text("\"open");
    offer_byte(NUL_BYTE);
    send_text("\"");
    offer_byte(NUL_BYTE);
    send_text("\"esc\\");
    offer_byte(NUL_BYTE);
    send_text("/");
    offer_byte(NUL_BYTE);
    send_text("// open");
    offer_byte(NUL_BYTE);
    send_text("/* open *");
    offer_byte(NUL_BYTE);
    wait_drained();

    // Random part: mostly well-formed fragments with random content, some
    // noise, truncated strings and comments, and stray end-of-stream bytes.
    for (int frag = 0; bytes_sent < ITEM_TARGET; frag++) begin
      if (frag == 100) begin
        // Starve the output while bytes keep coming so the queue fills up.
        holdoff_asked++;
        steady = 1'b1;
        repeat (40) offer_byte(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
        steady = 1'b0;
      end
      if (frag == 250) wait_drained();

      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        repeat ($urandom_range(1, 3)) offer_byte(BLANKS[$urandom_range(0, 5)]);
      end else if (pick < 32) begin
        offer_byte(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
      end else if (pick < 50) begin
        len = $urandom_range(0, 7);
        offer_byte(random_letter());
        for (int i = 0; i < len; i++) begin
          sel = $urandom_range(0, 9);
          if (sel < 5)       offer_byte(random_letter());
          else if (sel < 8)  offer_byte(8'($urandom_range("0", "9")));
          else if (sel == 8) offer_byte("_");
          else               offer_byte(":");
        end
      end else if (pick < 56) begin
        sel = $urandom_range(0, 5);
        send_text(keywords[sel]);
      end else if (pick < 68) begin
        len = $urandom_range(1, 4);
        repeat (len) offer_byte(8'($urandom_range("0", "9")));
        if ($urandom_range(0, 1) == 1) begin
          offer_byte(($urandom_range(0, 1) == 1) ? "." : "f");
          len = $urandom_range(0, 3);
          repeat (len) offer_byte(8'($urandom_range("0", "9")));
          if ($urandom_range(0, 5) == 0) offer_byte(".");
        end
      end else if (pick < 78) begin
        offer_byte("\"");
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            offer_byte("\\");
            offer_byte(8'($urandom_range(1, 255)));
          end else begin
            c = 8'($urandom_range(1, 255));
            if (c == "\"" || c == "\\") c = "q";
            offer_byte(c);
          end
        end
        // Now and then leave the string open and end the stream.
        offer_byte(($urandom_range(0, 11) == 0) ? NUL_BYTE : 8'("\""));
      end else if (pick < 83) begin
        send_text("//");
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(1, 255));
          offer_byte((c == "\n" || c == CR_BYTE) ? 8'("-") : c);
        end
        sel = $urandom_range(0, 9);
        offer_byte((sel == 0) ? NUL_BYTE : ((sel < 5) ? 8'("\n") : CR_BYTE));
      end else if (pick < 88) begin
        send_text("/*");
        repeat ($urandom_range(0, 8)) begin
          sel = $urandom_range(0, 3);
          offer_byte((sel == 0) ? 8'("*") : ((sel == 1) ? 8'("/") :
                     ((sel == 2) ? 8'(" ") : 8'("a"))));
        end
        if ($urandom_range(0, 9) == 0) offer_byte(NUL_BYTE);
        else                           send_text("*/");
      end else if (pick < 91) begin
        offer_byte("/");
      end else if (pick < 97) begin
        offer_byte(8'($urandom_range(1, 255)));
      end else begin
        offer_byte(NUL_BYTE);
      end
    end

    // Close whatever is open, let the pipe drain and allow a short tail for
    // any stray word before the verdict.
    offer_byte(NUL_BYTE);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tl_pkg.sv
rtl/core/tl_byte_if.sv
rtl/core/tl_tok_if.sv
rtl/core/tl_front.sv
rtl/core/tl_queue.sv
rtl/core/tl_back.sv
rtl/core/token_lexer.sv
tb/tl_token_checker.sv
tb/tb_token_lexer.sv
